>>> design/dfn_pkg.sv
`default_nettype none

package dfn_pkg;

	localparam int DEPTH_W    = 15;
	localparam int PIXEL_W    = 8;
	// depth * 240 fits in depth width + 8 bits
	localparam int DIVIDEND_W = DEPTH_W + PIXEL_W;
	// one extra quotient bit flags an overflowed (clipped) quotient
	localparam int QUOT_W     = PIXEL_W + 1;
	localparam int CNT_W      = $clog2(QUOT_W);

	localparam logic [DEPTH_W-1:0] THRESH_RESET = DEPTH_W'(32001);
	localparam logic [PIXEL_W-1:0] PIXEL_FULL   = 8'hff;
	localparam logic [PIXEL_W-1:0] PIXEL_ZERO   = 8'h00;

	localparam logic OP_SCAN      = 1'b0;
	localparam logic OP_NORMALIZE = 1'b1;

	typedef enum logic {
		TOP_IDLE,
		TOP_WAIT
	} top_state_t;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RUN,
		DIV_DONE
	} div_state_t;

	typedef struct packed {
		logic start;
		logic ack;
	} div_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

>>> design/dfn_max_tracker.sv
`default_nettype none

module dfn_max_tracker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        scan_en,
	input  wire logic                        clear,
	input  wire logic                        unsat,
	input  wire logic [dfn_pkg::DEPTH_W-1:0] depth,
	output logic      [dfn_pkg::DEPTH_W-1:0] frame_max
);

	logic [dfn_pkg::DEPTH_W-1:0] max_q;
	logic [dfn_pkg::DEPTH_W-1:0] base;
	logic [dfn_pkg::DEPTH_W-1:0] max_d;

	// frame start clears before the sample is considered
	always_comb begin
		base  = clear ? '0 : max_q;
		max_d = (unsat && (depth > base)) ? depth : base;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= '0;
		end else if (scan_en) begin
			max_q <= max_d;
		end
	end

	assign frame_max = max_q;

endmodule

`default_nettype wire

>>> design/dfn_divider.sv
`default_nettype none

module dfn_divider (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire dfn_pkg::div_ctrl_t             ctrl,
	input  wire logic [dfn_pkg::DIVIDEND_W-1:0] dividend,
	input  wire logic [dfn_pkg::DEPTH_W-1:0]    divisor,
	output dfn_pkg::div_stat_t                  stat,
	output logic      [dfn_pkg::QUOT_W-1:0]     quotient
);

	dfn_pkg::div_state_t state_q;
	dfn_pkg::div_state_t state_d;

	logic [dfn_pkg::DIVIDEND_W-1:0] rem_q;
	logic [dfn_pkg::DIVIDEND_W-1:0] dvs_q;
	logic [dfn_pkg::QUOT_W-1:0]     quo_q;
	logic [dfn_pkg::CNT_W-1:0]      cnt_q;
	logic                           ge;

	// one restoring step per cycle: divisor shifts right, quotient shifts in a bit
	assign ge = (rem_q >= dvs_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			dfn_pkg::DIV_IDLE: begin
				if (ctrl.start) state_d = dfn_pkg::DIV_RUN;
			end
			dfn_pkg::DIV_RUN: begin
				if (cnt_q == '0) state_d = dfn_pkg::DIV_DONE;
			end
			dfn_pkg::DIV_DONE: begin
				if (ctrl.ack) state_d = dfn_pkg::DIV_IDLE;
			end
			default: state_d = dfn_pkg::DIV_IDLE;
		endcase
	end

	always_comb begin
		stat.busy = (state_q == dfn_pkg::DIV_RUN);
		stat.done = (state_q == dfn_pkg::DIV_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dfn_pkg::DIV_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == dfn_pkg::DIV_IDLE) begin
				cnt_q <= dfn_pkg::CNT_W'(dfn_pkg::QUOT_W - 1);
			end else if (state_q == dfn_pkg::DIV_RUN) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == dfn_pkg::DIV_IDLE && ctrl.start) begin
			rem_q <= dividend;
			dvs_q <= {divisor, {(dfn_pkg::QUOT_W - 1){1'b0}}};
			quo_q <= '0;
		end else if (state_q == dfn_pkg::DIV_RUN) begin
			if (ge) rem_q <= rem_q - dvs_q;
			dvs_q <= dvs_q >> 1;
			quo_q <= {quo_q[dfn_pkg::QUOT_W-2:0], ge};
		end
	end

	assign quotient = quo_q;

endmodule

`default_nettype wire

>>> design/depth_frame_normalizer.sv
// Depth frame normalizer. Each frame is streamed twice. Scan requests
// (tuser[0] = 0) update the running maximum of samples strictly below
// saturation_threshold; tuser[1] on a scan request clears the maximum first.
// Scan requests produce no output. Normalize requests (tuser[0] = 1) produce
// one byte: 0 for a saturated sample, 255 when the maximum is zero, else
// 255 - floor(depth*240/max), clipped at 0. A scan request, a saturated
// sample or a zero maximum skips the divider. Any other normalize
// request runs a bit-serial restoring divider that resolves one quotient bit
// per cycle over 9 bits (8 result bits plus an overflow bit), so such a
// request holds off the next accept until its byte is in the output register.
// The output byte sits in a register, so input is taken while a result waits
// as long as the consumer drains it in the same cycle or the slot is empty.
// saturation_threshold resets to 32001; write it only while the block is idle.
`default_nettype none

module depth_frame_normalizer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// cfg: saturation_threshold
	input  wire logic        cfg_wr_en,
	input  wire logic [14:0] cfg_wr_data,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,   // [14:0] depth_sample, [15] zero
	input  wire logic [1:0]  s_axis_tuser,   // [0] opcode, [1] frame_start
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata    // [7:0] pixel_value
);

	dfn_pkg::top_state_t state_q;
	dfn_pkg::top_state_t state_d;

	logic [dfn_pkg::DEPTH_W-1:0]    thresh_q;
	logic [dfn_pkg::DEPTH_W-1:0]    frame_max;
	logic [dfn_pkg::DEPTH_W-1:0]    depth;
	logic [dfn_pkg::DIVIDEND_W-1:0] dividend;
	logic [dfn_pkg::QUOT_W-1:0]     quotient;
	logic [dfn_pkg::PIXEL_W-1:0]    fast_pixel;
	logic [dfn_pkg::PIXEL_W-1:0]    div_pixel;
	logic [dfn_pkg::PIXEL_W-1:0]    out_data_q;
	logic                           out_valid_q;

	logic accept;
	logic is_norm;
	logic unsat;
	logic slot_free;
	logic load_fast;
	logic drain;

	dfn_pkg::div_ctrl_t div_ctrl;
	dfn_pkg::div_stat_t div_stat;

	assign depth     = s_axis_tdata[dfn_pkg::DEPTH_W-1:0];
	assign is_norm   = (s_axis_tuser[0] == dfn_pkg::OP_NORMALIZE);
	assign unsat     = (depth < thresh_q);
	assign accept    = s_axis_tvalid && s_axis_tready;
	// output slot can take a new byte this cycle
	assign slot_free = !out_valid_q || m_axis_tready;

	// depth*240 = depth*256 - depth*16
	assign dividend = {depth, 8'b0} - {4'b0, depth, 4'b0};

	// saturated and zero-max samples skip the divider
	assign load_fast  = accept && is_norm && (!unsat || (frame_max == '0));
	assign fast_pixel = unsat ? dfn_pkg::PIXEL_FULL : dfn_pkg::PIXEL_ZERO;

	// 255 - q is ~q; overflow bit means the quotient clips at 255
	assign div_pixel = quotient[dfn_pkg::QUOT_W-1] ? dfn_pkg::PIXEL_ZERO
	                 : ~quotient[dfn_pkg::PIXEL_W-1:0];

	// cfg register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= dfn_pkg::THRESH_RESET;
		end else if (cfg_wr_en) begin
			thresh_q <= cfg_wr_data;
		end
	end

	dfn_max_tracker u_max (
		.clk       (clk),
		.arst_n    (arst_n),
		.scan_en   (accept && !is_norm),
		.clear     (s_axis_tuser[1]),
		.unsat     (unsat),
		.depth     (depth),
		.frame_max (frame_max)
	);

	dfn_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.dividend (dividend),
		.divisor  (frame_max),
		.stat     (div_stat),
		.quotient (quotient)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dfn_pkg::TOP_IDLE: begin
				if (accept && is_norm && unsat && (frame_max != '0)) begin
					state_d = dfn_pkg::TOP_WAIT;
				end
			end
			dfn_pkg::TOP_WAIT: begin
				if (div_stat.done && slot_free) state_d = dfn_pkg::TOP_IDLE;
			end
			default: state_d = dfn_pkg::TOP_IDLE;
		endcase
	end

	// outputs of the control FSM
	always_comb begin
		s_axis_tready  = 1'b0;
		drain          = 1'b0;
		div_ctrl.start = 1'b0;
		div_ctrl.ack   = 1'b0;
		case (state_q)
			dfn_pkg::TOP_IDLE: begin
				s_axis_tready  = slot_free;
				div_ctrl.start = accept && is_norm && unsat && (frame_max != '0);
			end
			dfn_pkg::TOP_WAIT: begin
				drain        = div_stat.done && slot_free;
				div_ctrl.ack = drain;
			end
			default: begin
				s_axis_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dfn_pkg::TOP_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_fast || drain) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_fast) begin
			out_data_q <= fast_pixel;
		end else if (drain) begin
			out_data_q <= div_pixel;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
	// divider result is taken only once it is final
	a_ack_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_ctrl.ack |-> div_stat.done)
		else $error("divider acked before done");

	// fast path and divider path never compete for the output register
	a_one_source: assert property (@(posedge clk) disable iff (!arst_n)
		!(load_fast && drain))
		else $error("two sources load the output register");

	// a started division keeps the block busy on the next cycle
	a_start_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_ctrl.start |=> (state_q == dfn_pkg::TOP_WAIT) && div_stat.busy)
		else $error("division start did not enter wait");

	// while waiting, the divider is either running or holding a result
	a_wait_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dfn_pkg::TOP_WAIT) |-> (div_stat.busy || div_stat.done))
		else $error("waiting on an idle divider");
`endif

endmodule

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import dfn_pkg::*;

	localparam int RANDOM_ITEMS  = 750;
	// covers a normalize request still in the divider; leave some margin
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int MAX_GAP       = 13;
	localparam int DIRECTED_ROWS = 25;
	localparam logic [PIXEL_W-1:0] SCALE = 8'hf0;

	// directed row kinds: request checked by predictor, request with a
	// literal expected pixel, or a threshold write
	typedef enum logic [1:0] {
		ROW_REQUEST,
		ROW_CHECKED,
		ROW_THRESHOLD
	} row_kind_t;

	typedef struct packed {
		row_kind_t          kind;
		logic               op;
		logic               start;
		logic [DEPTH_W-1:0] value;
		logic [PIXEL_W-1:0] pixel;
	} stim_row_t;

	logic               clk           = 1'b0;
	logic               arst_n        = 1'b0;
	logic               cfg_wr_en     = 1'b0;
	logic [DEPTH_W-1:0] cfg_wr_data   = '0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [15:0]        s_axis_tdata  = '0;   // [14:0] depth_sample, [15] zero
	logic [1:0]         s_axis_tuser  = '0;   // [0] opcode, [1] frame_start
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [PIXEL_W-1:0] m_axis_tdata;         // [7:0] pixel_value

	// predictor state
	logic [DEPTH_W-1:0] sat_threshold = THRESH_RESET;
	logic [DEPTH_W-1:0] frame_max     = '0;
	logic [PIXEL_W-1:0] expected_pixels [$];

	int  sent_count     = 0;
	int  mismatch_count = 0;
	int  cycle_count    = 0;
	bit  src_burst      = 1'b0;
	bit  snk_burst      = 1'b0;

	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		// empty maximum after reset
		'{ROW_CHECKED,   OP_NORMALIZE, 1'b0, 15'd100,   PIXEL_FULL},
		'{ROW_CHECKED,   OP_NORMALIZE, 1'b0, 15'd32001, PIXEL_ZERO},
		// frame start on a normalize request has no effect
		'{ROW_CHECKED,   OP_NORMALIZE, 1'b1, 15'd32767, PIXEL_ZERO},
		'{ROW_REQUEST,   OP_SCAN,      1'b1, 15'd1000,  PIXEL_ZERO},
		'{ROW_REQUEST,   OP_SCAN,      1'b0, 15'd32767, PIXEL_ZERO},
		'{ROW_REQUEST,   OP_SCAN,      1'b0, 15'd32000, PIXEL_ZERO},
		'{ROW_CHECKED,   OP_NORMALIZE, 1'b0, 15'd0,     PIXEL_FULL},
		'{ROW_CHECKED,   OP_NORMALIZE, 1'b0, 15'd32000, 8'h0f},
		'{ROW_CHECKED,   OP_NORMALIZE, 1'b1, 15'd16000, 8'h87},
		'{ROW_REQUEST,   OP_NORMALIZE, 1'b0, 15'd12345, PIXEL_ZERO},
		'{ROW_REQUEST,   OP_NORMALIZE, 1'b0, 15'd1000,  PIXEL_ZERO},
		// tiny maximum: sample above it clips the quotient
		'{ROW_REQUEST,   OP_SCAN,      1'b1, 15'd1,     PIXEL_ZERO},
		'{ROW_CHECKED,   OP_NORMALIZE, 1'b0, 15'd1,     8'h0f},
		'{ROW_CHECKED,   OP_NORMALIZE, 1'b0, 15'd2,     PIXEL_ZERO},
		// threshold zero: everything saturates
		'{ROW_THRESHOLD, OP_SCAN,      1'b0, 15'd0,     PIXEL_ZERO},
		'{ROW_REQUEST,   OP_SCAN,      1'b1, 15'd0,     PIXEL_ZERO},
		'{ROW_REQUEST,   OP_SCAN,      1'b0, 15'd21845, PIXEL_ZERO},
		'{ROW_CHECKED,   OP_NORMALIZE, 1'b0, 15'd0,     PIXEL_ZERO},
		'{ROW_CHECKED,   OP_NORMALIZE, 1'b0, 15'd32767, PIXEL_ZERO},
		// largest threshold
		'{ROW_THRESHOLD, OP_SCAN,      1'b0, 15'd32767, PIXEL_ZERO},
		'{ROW_REQUEST,   OP_SCAN,      1'b1, 15'd32766, PIXEL_ZERO},
		'{ROW_CHECKED,   OP_NORMALIZE, 1'b0, 15'd32766, 8'h0f},
		'{ROW_CHECKED,   OP_NORMALIZE, 1'b0, 15'd32767, PIXEL_ZERO},
		'{ROW_REQUEST,   OP_NORMALIZE, 1'b0, 15'd10922, PIXEL_ZERO},
		'{ROW_REQUEST,   OP_SCAN,      1'b0, 15'd21845, PIXEL_ZERO}
	};

	depth_frame_normalizer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// 255 - floor(depth*240/max), clipped; 0 when saturated, 255 on empty max
	function automatic logic [PIXEL_W-1:0] normalized_pixel(input logic [DEPTH_W-1:0] depth);
		logic [DIVIDEND_W-1:0] product;
		logic [DIVIDEND_W-1:0] quotient;
		if (depth >= sat_threshold)
			return PIXEL_ZERO;
		if (frame_max == '0)
			return PIXEL_FULL;
		product  = DIVIDEND_W'(depth) * DIVIDEND_W'(SCALE);
		quotient = product / DIVIDEND_W'(frame_max);
		if (quotient > DIVIDEND_W'(PIXEL_FULL))
			quotient = DIVIDEND_W'(PIXEL_FULL);
		return PIXEL_FULL - quotient[PIXEL_W-1:0];
	endfunction

	// depths biased toward the threshold boundary and the range ends
	function automatic logic [DEPTH_W-1:0] pick_depth();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: begin
				if (sat_threshold == '0)
					return '0;
				return sat_threshold - DEPTH_W'($urandom_range(0, 1));
			end
			3, 4: return DEPTH_W'($urandom);
			default: begin
				if (sat_threshold == '0)
					return DEPTH_W'($urandom);
				return DEPTH_W'($urandom_range(0, int'(sat_threshold) - 1));
			end
		endcase
	endfunction

	// Drive one request and wait for its accept. valid stays high after the
	// accept only when the next request follows with no gap, so the flag sees
	// a single assignment per time step.
	task automatic send_request(input logic op, input logic start,
		input logic [DEPTH_W-1:0] depth, input logic has_literal,
		input logic [PIXEL_W-1:0] literal);
		int gap;
		gap = src_burst ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {1'b0, depth};
		s_axis_tuser  <= {start, op};
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		sent_count++;
		if (op == OP_SCAN) begin
			if (start)
				frame_max = '0;
			if (depth < sat_threshold && depth > frame_max)
				frame_max = depth;
		end else begin
			expected_pixels.push_back(has_literal ? literal : normalized_pixel(depth));
		end
	endtask

	// Scan requests give no result, so an empty queue cannot show that the
	// last one is done; wait SETTLE_CYCLES as well.
	task automatic settle_block();
		s_axis_tvalid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [DEPTH_W-1:0] value);
		settle_block();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en     <= 1'b0;
		sat_threshold = value;
	endtask

	// One frame: mostly a scan pass then a normalize pass over the same
	// samples; sometimes a broken frame (start flag misplaced) or pure noise.
	task automatic run_frame();
		int                 size;
		int                 style;
		logic               start;
		logic [DEPTH_W-1:0] depth;
		logic [DEPTH_W-1:0] scanned [$];
		size  = $urandom_range(1, 12);
		style = $urandom_range(0, 9);
		if (style == 9) begin
			repeat (size)
				send_request(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					DEPTH_W'($urandom), 1'b0, PIXEL_ZERO);
		end else begin
			for (int i = 0; i < size; i++) begin
				depth = pick_depth();
				scanned.push_back(depth);
				if (style == 8)
					start = ($urandom_range(0, 3) == 0);
				else
					start = (i == 0);
				send_request(OP_SCAN, start, depth, 1'b0, PIXEL_ZERO);
			end
			foreach (scanned[i]) begin
				depth = ($urandom_range(0, 3) == 0) ? pick_depth() : scanned[i];
				send_request(OP_NORMALIZE, 1'($urandom_range(0, 1)), depth, 1'b0, PIXEL_ZERO);
			end
		end
	endtask

	// pixel sink: random stalls, compare against the oldest expectation
	initial begin : pixel_sink
		int                 stall;
		logic [PIXEL_W-1:0] want;
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			stall = snk_burst ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (m_axis_tvalid !== 1'b1);
			if (expected_pixels.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected pixel, expected none, actual 0x%02h",
					$time, m_axis_tdata);
			end else begin
				want = expected_pixels.pop_front();
				if (m_axis_tdata !== want) begin
					mismatch_count++;
					$display("%0t: pixel mismatch, expected 0x%02h, actual 0x%02h",
						$time, want, m_axis_tdata);
				end
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin : stimulus
		int random_start;
		int pick;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			case (directed_rows[i].kind)
				ROW_THRESHOLD: write_threshold(directed_rows[i].value);
				ROW_CHECKED: send_request(directed_rows[i].op, directed_rows[i].start,
					directed_rows[i].value, 1'b1, directed_rows[i].pixel);
				default: send_request(directed_rows[i].op, directed_rows[i].start,
					directed_rows[i].value, 1'b0, PIXEL_ZERO);
			endcase
		end

		// random phases: new threshold, new idling mode, a few frames
		random_start = sent_count;
		while (sent_count - random_start < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 5);
			case (pick)
				0: write_threshold('0);
				1: write_threshold('1);
				2: write_threshold(THRESH_RESET);
				3: write_threshold(DEPTH_W'($urandom));
				default: write_threshold(DEPTH_W'($urandom_range(1000, 32767)));
			endcase
			src_burst = ($urandom_range(0, 3) == 0);
			snk_burst = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(2, 6))
				run_frame();
		end

		settle_block();
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

>>> depth_frame_normalizer.f
design/dfn_pkg.sv
design/dfn_max_tracker.sv
design/dfn_divider.sv
design/depth_frame_normalizer.sv
verif/testbench.sv
